// ===== hdl/i2cmws_pkg.sv =====
// shared types and constants for the i2c master write sequencer
// no dependencies; used by every module of the block
package i2cmws_pkg;

  localparam int unsigned ValueWidth     = 8;
  localparam int unsigned HalfWidth      = 16;
  localparam logic [HalfWidth-1:0] HalfPeriodReset = 16'd750;
  localparam int unsigned BitsPerByte    = 8;
  localparam int unsigned BitCntWidth    = $clog2(BitsPerByte);
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QueuePtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth  = $clog2(QueueDepth + 1);
  localparam int unsigned OutDataWidth   = 8;

  localparam logic ModeData    = 1'b0;
  localparam logic ModeAddress = 1'b1;

  // phase step within a condition or bit slot
  localparam logic [1:0] StepSetData  = 2'd0;
  localparam logic [1:0] StepSclHigh  = 2'd1;
  localparam logic [1:0] StepSclLow   = 2'd2;
  localparam logic [1:0] StepStopHold = 2'd3;

  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] tx_byte;
    logic                  stop;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_ACK   = 5'b01000,
    ST_STOP  = 5'b10000
  } state_e;

endpackage

// ===== hdl/i2cmws_front.sv =====
// front end: accepts input transactions and turns them into byte commands
// depends on i2cmws_pkg
module i2cmws_front (
  input  logic                             s_valid_i,
  input  logic                             s_mode_i,
  input  logic [i2cmws_pkg::ValueWidth-1:0] s_value_i,
  input  logic                             s_last_i,
  output logic                             s_ready_o,
  output logic                             push_o,
  output i2cmws_pkg::cmd_t                 cmd_o,
  input  logic                             full_i
);

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  always_comb begin
    cmd_o.start = (s_mode_i == i2cmws_pkg::ModeAddress);
    cmd_o.stop  = s_last_i;
    if (s_mode_i == i2cmws_pkg::ModeAddress) begin
      // address byte with write bit clear
      cmd_o.tx_byte = {s_value_i[i2cmws_pkg::ValueWidth-2:0], 1'b0};
    end else begin
      cmd_o.tx_byte = s_value_i;
    end
  end

endmodule

// ===== hdl/i2cmws_queue.sv =====
// short command queue between the front and back ends
// depends on i2cmws_pkg
module i2cmws_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cmws_pkg::cmd_t push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output i2cmws_pkg::cmd_t pop_cmd_o
);

  i2cmws_pkg::cmd_t mem_q [i2cmws_pkg::QueueDepth];
  logic [i2cmws_pkg::QueuePtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [i2cmws_pkg::QueueCntWidth-1:0] count_q;

  assign full_o    = (count_q == i2cmws_pkg::QueueCntWidth'(i2cmws_pkg::QueueDepth));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == i2cmws_pkg::QueuePtrWidth'(i2cmws_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == i2cmws_pkg::QueuePtrWidth'(i2cmws_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/i2cmws_back.sv =====
// back end: walks each command through its line phases, paced by the half period
// depends on i2cmws_pkg; fed from i2cmws_queue
module i2cmws_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [i2cmws_pkg::HalfWidth-1:0]  half_period_i,
  input  logic                              empty_i,
  input  i2cmws_pkg::cmd_t                  cmd_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_scl_o,
  output logic                              out_sda_o,
  output logic                              out_last_o
);

  i2cmws_pkg::state_e state_q, state_d;
  logic [1:0]                            step_q, step_d;
  logic [i2cmws_pkg::BitCntWidth-1:0]    bit_q, bit_d;
  logic [i2cmws_pkg::ValueWidth-1:0]     shift_q, shift_d;
  logic                                  stop_q, stop_d;
  logic [i2cmws_pkg::HalfWidth-1:0]      timer_q;
  logic                                  scl_lvl_q;
  logic                                  out_valid_q, out_scl_q, out_sda_q, out_last_q;

  logic slot_free, emit, ph_scl, ph_sda, ph_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (state_q != i2cmws_pkg::ST_IDLE) && (timer_q == '0) && slot_free;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    stop_d  = stop_q;
    pop_o   = 1'b0;
    ph_scl  = 1'b1;
    ph_sda  = 1'b1;
    ph_last = 1'b0;
    case (state_q)
      i2cmws_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          shift_d = cmd_i.tx_byte;
          stop_d  = cmd_i.stop;
          step_d  = i2cmws_pkg::StepSetData;
          bit_d   = '0;
          state_d = cmd_i.start ? i2cmws_pkg::ST_START : i2cmws_pkg::ST_DATA;
        end
      end
      i2cmws_pkg::ST_START: begin
        case (step_q)
          i2cmws_pkg::StepSetData: begin ph_scl = scl_lvl_q; ph_sda = 1'b1; end
          i2cmws_pkg::StepSclHigh: begin ph_scl = 1'b1;      ph_sda = 1'b1; end
          i2cmws_pkg::StepSclLow:  begin ph_scl = 1'b1;      ph_sda = 1'b0; end
          default:                 begin ph_scl = 1'b0;      ph_sda = 1'b0; end
        endcase
        if (emit) begin
          if (step_q == i2cmws_pkg::StepStopHold) begin
            step_d  = i2cmws_pkg::StepSetData;
            state_d = i2cmws_pkg::ST_DATA;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      i2cmws_pkg::ST_DATA: begin
        ph_sda = shift_q[i2cmws_pkg::ValueWidth-1];
        case (step_q)
          i2cmws_pkg::StepSetData: ph_scl = scl_lvl_q;
          i2cmws_pkg::StepSclHigh: ph_scl = 1'b1;
          default:                 ph_scl = 1'b0;
        endcase
        if (emit) begin
          if (step_q == i2cmws_pkg::StepSclLow) begin
            step_d  = i2cmws_pkg::StepSetData;
            shift_d = {shift_q[i2cmws_pkg::ValueWidth-2:0], 1'b0};
            if (bit_q == i2cmws_pkg::BitCntWidth'(i2cmws_pkg::BitsPerByte - 1)) begin
              state_d = i2cmws_pkg::ST_ACK;
            end else begin
              bit_d = bit_q + 1'b1;
            end
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      i2cmws_pkg::ST_ACK: begin
        ph_sda = 1'b1;
        case (step_q)
          i2cmws_pkg::StepSetData: ph_scl = scl_lvl_q;
          i2cmws_pkg::StepSclHigh: ph_scl = 1'b1;
          default:                 ph_scl = 1'b0;
        endcase
        ph_last = (step_q == i2cmws_pkg::StepSclLow) && !stop_q;
        if (emit) begin
          if (step_q == i2cmws_pkg::StepSclLow) begin
            step_d  = i2cmws_pkg::StepSetData;
            state_d = stop_q ? i2cmws_pkg::ST_STOP : i2cmws_pkg::ST_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      i2cmws_pkg::ST_STOP: begin
        case (step_q)
          i2cmws_pkg::StepSetData: begin ph_scl = scl_lvl_q; ph_sda = 1'b0; end
          i2cmws_pkg::StepSclHigh: begin ph_scl = 1'b1;      ph_sda = 1'b0; end
          default:                 begin ph_scl = 1'b1;      ph_sda = 1'b1; end
        endcase
        ph_last = (step_q == i2cmws_pkg::StepStopHold);
        if (emit) begin
          if (step_q == i2cmws_pkg::StepStopHold) begin
            step_d  = i2cmws_pkg::StepSetData;
            state_d = i2cmws_pkg::ST_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = i2cmws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    stop_q  <= stop_d;
    bit_q   <= bit_d;
    if (emit) begin
      out_scl_q  <= ph_scl;
      out_sda_q  <= ph_sda;
      out_last_q <= ph_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2cmws_pkg::ST_IDLE;
      step_q      <= i2cmws_pkg::StepSetData;
      timer_q     <= '0;
      scl_lvl_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (emit) begin
        scl_lvl_q   <= ph_scl;
        out_valid_q <= 1'b1;
        // hold each phase for the half period
        timer_q <= (half_period_i == '0) ? '0 : half_period_i - 1'b1;
      end else begin
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
        if (timer_q != '0) begin
          timer_q <= timer_q - 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_scl_o   = out_scl_q;
  assign out_sda_o   = out_sda_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/i2c_master_write_sequencer.sv =====
// Write-only I2C master: each input transaction (address with START, or data byte,
// optionally followed by STOP) becomes a run of open-drain line phases on the
// output stream, one output transaction per phase, tlast on the final phase of
// the run. A data byte gives 27 phases, an address byte 31, plus 4 with STOP.
// Phases are paced by the phase timer of the back end from half_period_cycles,
// and held back while the output stalls. The next command is fetched while the
// last phase of a run is held, so at a half period of two or more no gap comes
// between runs; at a half period of one (or zero) the fetch adds an idle gap
// before the first phase of the next byte. Input is taken into a
// two-entry command queue while the back end is busy. The ACK slot is clocked
// but not sampled.
// depends on i2cmws_pkg, i2cmws_front, i2cmws_queue, i2cmws_back
module i2c_master_write_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [i2cmws_pkg::HalfWidth-1:0]  cfg_data_i,      // half_period_cycles
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [i2cmws_pkg::ValueWidth-1:0] s_axis_tdata_i,  // value
  input  logic                              s_axis_tuser_i,  // mode
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [i2cmws_pkg::OutDataWidth-1:0] m_axis_tdata_o, // scl_release, sda_release
  output logic                              m_axis_tlast_o
);

  logic [i2cmws_pkg::HalfWidth-1:0] half_period_q;
  logic             push, full, pop, empty, out_scl, out_sda;
  i2cmws_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cmws_pkg::HalfPeriodReset;
    end else if (cfg_valid_i) begin
      half_period_q <= cfg_data_i;
    end
  end

  i2cmws_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_mode_i  (s_axis_tuser_i),
    .s_value_i (s_axis_tdata_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .full_i    (full)
  );

  i2cmws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  i2cmws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_period_q),
    .empty_i       (empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_scl_o     (out_scl),
    .out_sda_o     (out_sda),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(i2cmws_pkg::OutDataWidth - 2){1'b0}}, out_sda, out_scl};

endmodule

// ===== bench/tb_i2c_master_write_sequencer.sv =====
`timescale 1ns / 100ps
// testbench for i2c_master_write_sequencer: directed and random byte transactions,
// each predicted as a run of scl/sda line phases and checked on the output stream
// depends on i2cmws_pkg and the i2c_master_write_sequencer rtl
module tb_i2c_master_write_sequencer;

  localparam int unsigned CycleLimit   = 12_000_000;
  localparam int unsigned MaxRunPhases = 35;

  typedef struct packed {
    logic scl;
    logic sda;
    logic eor;
  } line_phase_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni;
  logic                                  cfg_valid_i;
  logic                                  cfg_ready_o;
  logic [i2cmws_pkg::HalfWidth-1:0]      cfg_data_i;
  logic                                  s_axis_tvalid_i;
  logic                                  s_axis_tready_o;
  logic [i2cmws_pkg::ValueWidth-1:0]     s_axis_tdata_i;
  logic                                  s_axis_tuser_i;
  logic                                  s_axis_tlast_i;
  logic                                  m_axis_tvalid_o;
  logic                                  m_axis_tready_i;
  logic [i2cmws_pkg::OutDataWidth-1:0]   m_axis_tdata_o;
  logic                                  m_axis_tlast_o;

  i2c_master_write_sequencer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  logic                                  scl_level;
  logic                                  sda_level;
  logic [i2cmws_pkg::HalfWidth-1:0]      half_period;
  line_phase_t                           pending_phases[$];
  line_phase_t                           run_buf[MaxRunPhases];
  int unsigned                           run_len;
  int unsigned                           send_idle_pct  = 0;
  int unsigned                           recv_stall_pct = 0;
  int unsigned                           items_sent     = 0;
  int unsigned                           mismatch_count = 0;
  int unsigned                           cycle_count    = 0;
  line_phase_t                           want_phase;
  logic [i2cmws_pkg::OutDataWidth-1:0]   want_data;

  function automatic void put_phase(input logic scl, input logic sda);
    scl_level = scl;
    sda_level = sda;
    run_buf[run_len] = {scl, sda, 1'b0};
    run_len++;
  endfunction

  task automatic predict_line_run(input logic mode,
                                  input logic [i2cmws_pkg::ValueWidth-1:0] value,
                                  input logic last);
    logic [i2cmws_pkg::ValueWidth-1:0] tx;
    line_phase_t ph;
    run_len = 0;
    if (mode == i2cmws_pkg::ModeAddress) begin
      put_phase(scl_level, 1'b1);
      put_phase(1'b1, 1'b1);
      put_phase(1'b1, 1'b0);
      put_phase(1'b0, 1'b0);
      tx = {value[i2cmws_pkg::ValueWidth-2:0], 1'b0};
    end else begin
      tx = value;
    end
    for (int b = i2cmws_pkg::BitsPerByte - 1; b >= 0; b--) begin
      put_phase(scl_level, tx[b]);
      put_phase(1'b1, tx[b]);
      put_phase(1'b0, tx[b]);
    end
    // ack slot, released and clocked
    put_phase(scl_level, 1'b1);
    put_phase(1'b1, 1'b1);
    put_phase(1'b0, 1'b1);
    if (last) begin
      put_phase(scl_level, 1'b0);
      put_phase(1'b1, 1'b0);
      put_phase(1'b1, 1'b1);
      put_phase(1'b1, 1'b1);
    end
    for (int i = 0; i < run_len; i++) begin
      ph = run_buf[i];
      ph.eor = (i == run_len - 1);
      pending_phases.push_back(ph);
    end
  endtask

  task automatic send_item(input logic mode, input logic [i2cmws_pkg::ValueWidth-1:0] value,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= last;
    predict_line_run(mode, value, last);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_half_period(input logic [i2cmws_pkg::HalfWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    half_period = value;
  endtask

  task automatic wait_runs_done();
    s_axis_tvalid_i <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk_i);
    repeat (int'(half_period) + 16) @(posedge clk_i);
  endtask

  task automatic send_random_transfer();
    int unsigned n_data;
    logic        stop_at_end;
    if ($urandom_range(99) < 15) begin
      send_item(1'($urandom_range(1)), i2cmws_pkg::ValueWidth'($urandom),
                1'($urandom_range(1)));
    end else begin
      n_data      = $urandom_range(1, 4);
      stop_at_end = ($urandom_range(99) >= 20);
      send_item(i2cmws_pkg::ModeAddress, i2cmws_pkg::ValueWidth'($urandom), 1'b0);
      for (int i = 1; i <= n_data; i++) begin
        send_item(i2cmws_pkg::ModeData, i2cmws_pkg::ValueWidth'($urandom),
                  stop_at_end && (i == n_data));
      end
    end
  endtask

  task automatic test_data_without_start();
    send_item(i2cmws_pkg::ModeData, 8'h5A, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'hA5, 1'b1);
    wait_runs_done();
  endtask

  task automatic test_field_extremes();
    send_item(i2cmws_pkg::ModeAddress, 8'h00, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'h00, 1'b1);
    send_item(i2cmws_pkg::ModeAddress, 8'h7F, 1'b1);
    send_item(i2cmws_pkg::ModeAddress, 8'h7F, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'hFF, 1'b1);
    wait_runs_done();
  endtask

  task automatic test_address_msb_dropped();
    send_item(i2cmws_pkg::ModeAddress, 8'hFF, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'h80, 1'b0);
    send_item(i2cmws_pkg::ModeAddress, 8'h80, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'h01, 1'b1);
    wait_runs_done();
  endtask

  task automatic test_repeated_start();
    send_item(i2cmws_pkg::ModeAddress, 8'h55, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'h33, 1'b0);
    send_item(i2cmws_pkg::ModeAddress, 8'h2A, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'hCC, 1'b1);
    wait_runs_done();
  endtask

  task automatic test_zero_half_period();
    write_half_period('0);
    send_item(i2cmws_pkg::ModeAddress, 8'h2C, 1'b0);
    send_item(i2cmws_pkg::ModeData, 8'h0F, 1'b1);
    wait_runs_done();
  endtask

  task automatic test_longest_half_period();
    write_half_period('1);
    send_item(i2cmws_pkg::ModeData, 8'hC3, 1'b0);
    wait_runs_done();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_half_period(i2cmws_pkg::HalfWidth'($urandom_range(1, 4)));
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_transfer();
    wait_runs_done();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_phases.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected phase: tdata %h tlast %0b", m_axis_tdata_o, m_axis_tlast_o);
        end
        mismatch_count++;
      end else begin
        want_phase   = pending_phases.pop_front();
        want_data    = '0;
        want_data[0] = want_phase.scl;
        want_data[1] = want_phase.sda;
        if (m_axis_tdata_o !== want_data || m_axis_tlast_o !== want_phase.eor) begin
          if (mismatch_count < 10) begin
            $display({"phase mismatch: expected scl %0b sda %0b tdata %h tlast %0b,",
                      " got tdata %h tlast %0b"},
                     want_phase.scl, want_phase.sda, want_data, want_phase.eor,
                     m_axis_tdata_o, m_axis_tlast_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= i2cmws_pkg::ModeData;
    s_axis_tlast_i  <= 1'b0;
    scl_level       = 1'b1;
    sda_level       = 1'b1;
    half_period     = i2cmws_pkg::HalfPeriodReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_half_period(i2cmws_pkg::HalfWidth'(1));
    test_data_without_start();
    test_field_extremes();
    test_address_msb_dropped();
    test_repeated_start();
    test_zero_half_period();
    test_longest_half_period();
    test_random_traffic(0, 0, 110);
    test_random_traffic(51, 0, 110);
    test_random_traffic(0, 51, 110);
    test_random_traffic(36, 36, 110);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
